// ===== hw/rtl/epsem_hdr_pkg.sv =====
// ============================================================================
// EPSEM header deframer package
// Shared result kinds, field widths and the result word type.
// ============================================================================
`default_nettype none

package epsem_hdr_pkg;

    // Longest BER long-form length accepted, in bytes
    localparam int unsigned MAX_LENGTH_BYTES = 4;

    localparam int unsigned KIND_W = 2;

    // Result kinds (travel on tuser)
    localparam logic [KIND_W-1:0] KIND_HEADER  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_ERROR   = 2'd3;

    // Packed result data: 86 field bits, padded to 88
    localparam int unsigned RESULT_DATA_W = 88;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [7:0]        flag_byte;
        logic [31:0]       ed_class_value;
        logic [31:0]       service_length;
        logic [7:0]        payload_byte;
        logic              last;
    } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/epsem_header_deframer_unit.sv =====
// ============================================================================
// EPSEM header deframer unit
// Parses an EPSEM byte stream: flag byte, optional 4-byte class, BER length,
// then passes the payload through, emitting header/payload/empty/error words.
// ============================================================================
//
//  channel | dir | width        | contents
//  --------+-----+--------------+-----------------------------------------
//  s_      | in  | tdata 8      | raw message byte
//  m_      | out | tdata 88     | header fields + payload byte
//          |     | tuser 2      | result kind
//          |     | tlast 1      | final word of the message
//
//  One byte per cycle sustained while m_tready stays high. A byte is caught in
//  an input register, then decoded by the parser state logic into the result
//  register once that slot is free or draining; m_tvalid is driven by the
//  result register's valid.
//  aresetn (synchronous, active low) clears the parser phase and both stage
//  valids; data registers are not reset.
//  A stall on m_tready holds the result; the input register keeps filling,
//  and s_tready drops only once both stages are full.
//
`default_nettype none

module epsem_header_deframer_unit
    import epsem_hdr_pkg::*;
(
    input  wire logic                     aclk,
    input  wire logic                     aresetn,

    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    input  wire logic [7:0]               s_tdata,   // [7:0] data_byte

    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // [7:0] flag_byte, [39:8] ed_class_value, [71:40] service_length,
    // [79:72] payload_byte, [80] recovery_flag, [81] proxy_flag,
    // [83:82] sec_mode, [85:84] resp_mode, [87:86] zero
    output logic [RESULT_DATA_W-1:0]      m_tdata,
    output logic [KIND_W-1:0]             m_tuser,   // [1:0] kind
    output logic                          m_tlast    // last
);

    // Parser phases
    localparam logic [2:0] PH_FLAG    = 3'd0;
    localparam logic [2:0] PH_CLASS   = 3'd1;
    localparam logic [2:0] PH_LEN1    = 3'd2;
    localparam logic [2:0] PH_LENMORE = 3'd3;
    localparam logic [2:0] PH_PAYLOAD = 3'd4;

    localparam logic [6:0] MAX_LEN_B = 7'(MAX_LENGTH_BYTES);

    // ------------------------------------------------------------------
    // Input register stage
    // ------------------------------------------------------------------
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;

    // Result register stage
    logic       out_valid_reg, out_valid_next;
    result_t    out_reg, out_next;

    // Parser state
    logic [2:0]  phase_reg, phase_next;
    logic [7:0]  flags_reg, flags_next;
    logic [31:0] class_reg, class_next;
    logic [2:0]  count_reg, count_next;
    logic [31:0] len_reg, len_next;
    logic [2:0]  len_left_reg, len_left_next;
    logic [31:0] pay_left_reg, pay_left_next;

    logic        advance;   // input byte moves into the parser this cycle
    logic        emit;      // the byte yields a result word
    logic [31:0] len_shift;
    logic [31:0] pay_dec;
    logic [2:0]  left_dec;
    logic [6:0]  n_len;

    // The parser may consume a byte whenever the result slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign in_valid_next = s_tvalid ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    assign len_shift = {len_reg[23:0], in_byte_reg};
    assign pay_dec   = pay_left_reg - 32'd1;
    assign left_dec  = len_left_reg - 3'd1;
    assign n_len     = in_byte_reg[6:0];

    always_comb begin
        phase_next    = phase_reg;
        flags_next    = flags_reg;
        class_next    = class_reg;
        count_next    = count_reg;
        len_next      = len_reg;
        len_left_next = len_left_reg;
        pay_left_next = pay_left_reg;

        emit                   = 1'b0;
        out_next.kind          = KIND_HEADER;
        out_next.flag_byte     = flags_reg;
        out_next.ed_class_value = class_reg;
        out_next.service_length = len_reg;
        out_next.payload_byte  = 8'h00;
        out_next.last          = 1'b0;

        case (phase_reg)
            PH_FLAG: begin
                class_next    = '0;
                len_next      = '0;
                count_next    = '0;
                len_left_next = '0;
                pay_left_next = '0;
                if (in_byte_reg == 8'h00) begin
                    // empty message: every field zero
                    flags_next              = 8'h00;
                    emit                    = 1'b1;
                    out_next.kind           = KIND_EMPTY;
                    out_next.flag_byte      = 8'h00;
                    out_next.ed_class_value = '0;
                    out_next.service_length = '0;
                    out_next.last           = 1'b1;
                end else begin
                    flags_next = in_byte_reg;
                    phase_next = in_byte_reg[4] ? PH_CLASS : PH_LEN1;
                end
            end

            PH_CLASS: begin
                class_next = {class_reg[23:0], in_byte_reg};
                count_next = count_reg + 3'd1;
                if (count_reg + 3'd1 >= 3'd4) begin
                    count_next = '0;
                    phase_next = PH_LEN1;
                end
            end

            PH_LEN1: begin
                if (!in_byte_reg[7]) begin
                    // short form: header now
                    len_next                = {24'h0, in_byte_reg};
                    pay_left_next           = {24'h0, in_byte_reg};
                    emit                    = 1'b1;
                    out_next.service_length = {24'h0, in_byte_reg};
                    out_next.last           = (in_byte_reg == 8'h00);
                    phase_next = (in_byte_reg == 8'h00) ? PH_FLAG : PH_PAYLOAD;
                end else if (n_len == 7'd0 || n_len > MAX_LEN_B) begin
                    emit                    = 1'b1;
                    out_next.kind           = KIND_ERROR;
                    out_next.service_length = '0;
                    out_next.last           = 1'b1;
                    phase_next              = PH_FLAG;
                end else begin
                    len_next      = '0;
                    len_left_next = n_len[2:0];
                    phase_next    = PH_LENMORE;
                end
            end

            PH_LENMORE: begin
                len_next      = len_shift;
                len_left_next = left_dec;
                if (left_dec == 3'd0) begin
                    pay_left_next           = len_shift;
                    emit                    = 1'b1;
                    out_next.service_length = len_shift;
                    out_next.last           = (len_shift == 32'd0);
                    phase_next = (len_shift == 32'd0) ? PH_FLAG : PH_PAYLOAD;
                end
            end

            PH_PAYLOAD: begin
                pay_left_next         = pay_dec;
                emit                  = 1'b1;
                out_next.kind         = KIND_PAYLOAD;
                out_next.payload_byte = in_byte_reg;
                out_next.last         = (pay_dec == 32'd0);
                if (pay_dec == 32'd0) begin
                    phase_next = PH_FLAG;
                end
            end

            default: begin
                phase_next = PH_FLAG;
            end
        endcase
    end

    // Result slot: loaded when a consumed byte yields a word, freed when taken downstream
    assign out_valid_next = advance ? emit : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_FLAG;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance) begin
                phase_reg <= phase_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_byte_reg <= s_tdata;
        end
        if (advance) begin
            flags_reg    <= flags_next;
            class_reg    <= class_next;
            count_reg    <= count_next;
            len_reg      <= len_next;
            len_left_reg <= len_left_next;
            pay_left_reg <= pay_left_next;
            if (emit) begin
                out_reg <= out_next;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output packing; flag sub-fields are unpacked from the held flag byte
    // ------------------------------------------------------------------
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.last;
    assign m_tdata  = {2'b00,
                       out_reg.flag_byte[1:0],
                       out_reg.flag_byte[3:2],
                       out_reg.flag_byte[5],
                       out_reg.flag_byte[6],
                       out_reg.payload_byte,
                       out_reg.service_length,
                       out_reg.ed_class_value,
                       out_reg.flag_byte};

endmodule

`default_nettype wire
